/* rtl/pmac_pkg.sv */
// Shared types and constants for the pH median and average conditioner.
`default_nettype none
package pmac_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CODE_W     = 13;
    localparam int PH_W       = 16;
    localparam int SPR_W      = 5;
    localparam int GAIN_W     = 32;
    localparam int OFFSET_W   = 21;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_SHIFT = 16;
    localparam int PROD_W     = CODE_W + 1 + GAIN_W;
    localparam int PH_FULL_W  = PROD_W - PROD_SHIFT + 1;
    localparam int PH_MAX_Q12 = 57344;

    localparam logic [SPR_W-1:0]    SPR_RESET    = 5'd10;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd0;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 21'd28672;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES = 2'd0,
        CFG_GAIN    = 2'd1,
        CFG_OFFSET  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pmac_div_status_t;

endpackage
`default_nettype wire

/* rtl/pmac_divider.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pmac_divider #(
    parameter int DIVIDEND_W = 18,
    parameter int DIVISOR_W  = 5
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [DIVIDEND_W-1:0]   dividend,
    input  wire logic [DIVISOR_W-1:0]    divisor,
    output pmac_pkg::pmac_div_status_t   status,
    output logic      [DIVIDEND_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = ~diff[DIVISOR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && step_reg == STEP_W'(DIVIDEND_W - 1);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
            step_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], fits};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
`default_nettype wire

/* rtl/ph_median_average_conditioner.sv */
// Top level: burst median, moving average and pH conversion of ADC samples.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: adc_sample
//  m_        out  m_tvalid/m_tready    m_tdata: ph_value, filtered_code, median_code
//                                      m_tuser: clamped_low, clamped_high
//  cfg_      in   cfg_wr_en            cfg_index, cfg_data
//
//  A sample that does not close a burst is stored, and the block stays ready for
//  the next one. A closing sample of a burst starts a rank scan over the burst
//  memory, a ring sum over the filled ring entries, a division by the count of
//  filled entries and the pH conversion. s_tready is low while a burst is processed;
//  a waiting result stalls only the final load of the next one. Reset is
//  synchronous, active low.
`default_nettype none
module ph_median_average_conditioner #(
    parameter int MAX_SAMPLES   = 16,
    parameter int AVERAGE_DEPTH = 20,
    parameter int ADC_BITS      = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] adc_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] ph_value, [28:16] filtered_code,
                                        // [41:29] median_code
    output logic [1:0]       m_tuser,   // [0] clamped_low, [1] clamped_high
    input  wire logic        cfg_wr_en,
    input  wire logic [pmac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pmac_pkg::CFG_W-1:0]     cfg_data
);

    localparam int SW     = pmac_pkg::SAMPLE_W;
    localparam int CW     = pmac_pkg::CODE_W;
    localparam int NW     = $clog2(MAX_SAMPLES + 1);
    localparam int BIW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int RIW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(AVERAGE_DEPTH + 1);
    localparam int SUM_W  = $clog2(AVERAGE_DEPTH * ((1 << CW) - 2) + 1);
    localparam logic [SW-1:0] SAMPLE_MASK = SW'((1 << ADC_BITS) - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOADC = 10'b00_0000_0010,
        S_LATCH = 10'b00_0000_0100,
        S_SCAN  = 10'b00_0000_1000,
        S_PUSH  = 10'b00_0001_0000,
        S_SUM0  = 10'b00_0010_0000,
        S_SUM   = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    logic [pmac_pkg::SPR_W-1:0]    spr_reg;
    logic [pmac_pkg::GAIN_W-1:0]   gain_reg;
    logic [pmac_pkg::OFFSET_W-1:0] offset_reg;

    logic [SW-1:0] burst_mem [0:MAX_SAMPLES-1];
    logic [SW-1:0] brd_reg;
    logic [BIW-1:0] braddr;
    logic [NW-1:0] bcnt_reg;
    logic [NW-1:0] bcnt_inc;
    logic [NW-1:0] n_len;
    logic [NW-1:0] lo_rank;
    logic [NW-1:0] hi_rank;

    logic [BIW-1:0] i_reg;
    logic [BIW-1:0] jd_reg;
    logic [NW-1:0]  rank_reg;
    logic [NW-1:0]  rank_next;
    logic [SW-1:0]  cand_reg;
    logic [SW-1:0]  lo_val_reg;
    logic [SW-1:0]  hi_val_reg;
    logic           hit;
    logic [CW-1:0]  med_sum;

    logic [CW-1:0]    ring_mem [0:AVERAGE_DEPTH-1];
    logic [CW-1:0]    rrd_reg;
    logic [RIW-1:0]   raddr;
    logic [RIW-1:0]   ring_pos_reg;
    logic             ring_full_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RIW-1:0]   k_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;

    logic                        div_start;
    pmac_pkg::pmac_div_status_t  div_status;
    logic [SUM_W-1:0]            div_quo;

    logic [CW-1:0]  mean_reg;
    logic [CW-1:0]  median_reg;
    logic signed [pmac_pkg::PROD_W-1:0] prod_reg;
    logic [pmac_pkg::PH_FULL_W-1:0]     ph_full;
    logic           ph_low;
    logic           ph_high;
    logic [pmac_pkg::PH_W-1:0] ph_clamped;

    logic           m_valid_reg;
    logic [47:0]    m_data_reg;
    logic [1:0]     m_user_reg;
    logic           out_free;
    logic           s_take;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg    <= pmac_pkg::SPR_RESET;
            gain_reg   <= pmac_pkg::GAIN_RESET;
            offset_reg <= pmac_pkg::OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pmac_pkg::CFG_SAMPLES: spr_reg    <= cfg_data[pmac_pkg::SPR_W-1:0];
                pmac_pkg::CFG_GAIN:    gain_reg   <= cfg_data[pmac_pkg::GAIN_W-1:0];
                pmac_pkg::CFG_OFFSET:  offset_reg <= cfg_data[pmac_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (spr_reg == '0) begin
            n_len = NW'(1);
        end else if (int'(spr_reg) > MAX_SAMPLES) begin
            n_len = NW'(MAX_SAMPLES);
        end else begin
            n_len = NW'(spr_reg);
        end
    end

    assign lo_rank  = (n_len - NW'(1)) >> 1;
    assign hi_rank  = n_len >> 1;
    assign bcnt_inc = bcnt_reg + NW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign s_take   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // rank scan: a sample's rank counts smaller ones, ties broken by position
    assign hit = (brd_reg < cand_reg) || (brd_reg == cand_reg && jd_reg < i_reg);
    assign rank_next = rank_reg + NW'(hit);
    assign med_sum   = {1'b0, lo_val_reg} + {1'b0, hi_val_reg};
    assign acc_next  = acc_reg + SUM_W'(rrd_reg);

    always_comb begin
        case (state_reg)
            S_LOADC: braddr = i_reg;
            S_SCAN:  braddr = (jd_reg == BIW'(MAX_SAMPLES - 1)) ? '0 : jd_reg + BIW'(1);
            default: braddr = '0;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_SUM:   raddr = (k_reg == RIW'(AVERAGE_DEPTH - 1)) ? '0 : k_reg + RIW'(1);
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            burst_mem[bcnt_reg[BIW-1:0]] <= s_tdata[SW-1:0] & SAMPLE_MASK;
        end
        brd_reg <= burst_mem[braddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_PUSH) begin
            ring_mem[ring_pos_reg] <= med_sum;
        end
        rrd_reg <= ring_mem[raddr];
    end

    assign div_start = (state_reg == S_SUM) && (CNT_W'(k_reg) == cnt_reg - CNT_W'(1));

    pmac_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (cnt_reg),
        .status   (div_status),
        .quotient (div_quo)
    );

    assign ph_full = {prod_reg[pmac_pkg::PROD_W-1],
                      prod_reg[pmac_pkg::PROD_W-1:pmac_pkg::PROD_SHIFT]}
                   + {{(pmac_pkg::PH_FULL_W - pmac_pkg::OFFSET_W){offset_reg[pmac_pkg::OFFSET_W-1]}},
                      offset_reg};
    assign ph_low  = ph_full[pmac_pkg::PH_FULL_W-1];
    assign ph_high = !ph_low && (ph_full[pmac_pkg::PH_FULL_W-2:0] >
                                 (pmac_pkg::PH_FULL_W-1)'(pmac_pkg::PH_MAX_Q12));
    assign ph_clamped = ph_low  ? '0 :
                        ph_high ? pmac_pkg::PH_W'(pmac_pkg::PH_MAX_Q12) :
                                  ph_full[pmac_pkg::PH_W-1:0];

    // sequencer and control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bcnt_reg      <= '0;
            ring_pos_reg  <= '0;
            ring_full_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_take) begin
                        if (bcnt_inc >= n_len) begin
                            bcnt_reg  <= '0;
                            state_reg <= S_LOADC;
                        end else begin
                            bcnt_reg <= bcnt_inc;
                        end
                    end
                end
                S_LOADC: state_reg <= S_LATCH;
                S_LATCH: state_reg <= S_SCAN;
                S_SCAN: begin
                    if (NW'(jd_reg) == n_len - NW'(1)) begin
                        state_reg <= (NW'(i_reg) == n_len - NW'(1)) ? S_PUSH : S_LOADC;
                    end
                end
                S_PUSH: begin
                    if (ring_pos_reg == RIW'(AVERAGE_DEPTH - 1)) begin
                        ring_pos_reg  <= '0;
                        ring_full_reg <= 1'b1;
                    end else begin
                        ring_pos_reg <= ring_pos_reg + RIW'(1);
                    end
                    state_reg <= S_SUM0;
                end
                S_SUM0: state_reg <= S_SUM;
                S_SUM: begin
                    if (div_start) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_status.done) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                i_reg    <= '0;
                rank_reg <= '0;
            end
            S_LATCH: begin
                cand_reg <= brd_reg;
                jd_reg   <= '0;
                rank_reg <= '0;
            end
            S_SCAN: begin
                jd_reg   <= jd_reg + BIW'(1);
                rank_reg <= rank_next;
                if (NW'(jd_reg) == n_len - NW'(1)) begin
                    if (rank_next == lo_rank) begin
                        lo_val_reg <= cand_reg;
                    end
                    if (rank_next == hi_rank) begin
                        hi_val_reg <= cand_reg;
                    end
                    i_reg <= i_reg + BIW'(1);
                end
            end
            S_PUSH: begin
                median_reg <= med_sum;
                if (ring_pos_reg == RIW'(AVERAGE_DEPTH - 1) || ring_full_reg) begin
                    cnt_reg <= CNT_W'(AVERAGE_DEPTH);
                end else begin
                    cnt_reg <= CNT_W'(ring_pos_reg) + CNT_W'(1);
                end
            end
            S_SUM0: begin
                k_reg   <= '0;
                acc_reg <= '0;
            end
            S_SUM: begin
                k_reg   <= k_reg + RIW'(1);
                acc_reg <= acc_next;
            end
            S_MUL: begin
                mean_reg <= div_quo[CW-1:0];
                prod_reg <= $signed({1'b0, div_quo[CW-1:0]}) * $signed(gain_reg);
            end
            S_OUT: begin
                if (out_free) begin
                    m_data_reg <= {{(48 - 2 * CW - pmac_pkg::PH_W){1'b0}},
                                   median_reg, mean_reg, ph_clamped};
                    m_user_reg <= {ph_high, ph_low};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_ring_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(ring_pos_reg) < AVERAGE_DEPTH)
        else $error("ring position beyond depth");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (NW'(jd_reg) < n_len && NW'(i_reg) < n_len))
        else $error("rank scan index beyond burst length");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside output state");

    a_ph_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (int'(m_data_reg[pmac_pkg::PH_W-1:0]) <= pmac_pkg::PH_MAX_Q12
                         && !(m_user_reg[0] && m_user_reg[1])))
        else $error("pH result out of range or both clamp flags set");
`endif

endmodule
`default_nettype wire
